FILE: src/blrg_pkg.sv
// blrg_pkg: shared constants, state encoding and controller/datapath bundles
// for the linear ramp generator; no dependencies
package blrg_pkg;

  localparam int unsigned DATA_W    = 16;   // target and sample width
  localparam int unsigned LEN_W     = 7;    // block_len register width
  localparam int unsigned MAX_BLOCK = 64;   // longest ramp
  localparam int unsigned CNT_W     = 6;    // sample and divider step counter
  localparam int unsigned DIV_STEPS = DATA_W; // one quotient bit per step
  localparam int unsigned REM_W     = 6;    // divider remainder, always below MAX_BLOCK
  localparam int unsigned ACC_W     = DATA_W + 2; // ramp quotient and its step

  localparam logic [LEN_W-1:0] BLOCK_LEN_RST = LEN_W'(32);
  localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(MAX_BLOCK);
  localparam logic [LEN_W-1:0] LEN_MIN       = LEN_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_RAMP
  } blrg_state_e;

  typedef struct packed {
    logic load;       // capture target, length and difference
    logic div_step;   // one restoring division step
    logic setup;      // turn quotient into floored step, start the ramp
    logic ramp_step;  // advance to the next sample
    logic finish;     // store the last sample as the new level
  } blrg_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] len_m1;  // effective length minus one
  } blrg_sts_t;

endpackage

FILE: src/blrg_if.sv
// blrg_if: valid/ready channel interfaces for targets and ramp samples
// depends on blrg_pkg
interface blrg_in_if import blrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target;

  modport source (output valid, output target, input ready);
  modport sink (input valid, input target, output ready);
endinterface

interface blrg_out_if import blrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

FILE: src/block_linear_ramp_generator.sv
// block_linear_ramp_generator: top level of the linear ramp generator
// depends on blrg_pkg, blrg_if, blrg_ctrl and blrg_dp
//
// Each target transaction on in_i starts one ramp of L samples on out_o,
// L being block_len clamped to 1..64 (0 counts as 1, above 64 as 64).
// Sample i is ((target - level) * i + level * L) / L truncated toward zero,
// running from the stored level toward the target; the final sample has
// last set and becomes the stored level (zero after reset). block_len may
// only be written while no ramp is in progress. Per target: the target is
// accepted, the difference is divided by L bit-serially (one quotient bit
// per cycle), a setup step turns the quotient into the floored step, then
// one sample per cycle follows while out_o is ready. A new target is taken
// only once the last sample of the current ramp has been delivered.
module block_linear_ramp_generator import blrg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             block_len_we_i,
  input  logic [LEN_W-1:0] block_len_i,
  blrg_in_if.sink          in_i,
  blrg_out_if.source       out_o
);

  blrg_cmd_t cmd;
  blrg_sts_t sts;

  // sequencer: handshakes and step commands
  blrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_o.last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic: divider, ramp accumulator, level and length registers
  blrg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .block_len_we_i (block_len_we_i),
    .block_len_i    (block_len_i),
    .target_i       (in_i.target),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_o       (out_o.sample)
  );

`ifndef SYNTH
  // never accept a target while a ramp is being emitted
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("target accepted during ramp");

  // division always comes before the first sample
  a_div_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !out_o.valid)
    else $error("sample without division");

  // the final sample of a ramp frees the input
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("input not released after last sample");
`endif

endmodule

FILE: src/blrg_ctrl.sv
// blrg_ctrl: sequencer for division, setup and sample emission
// depends on blrg_pkg
module blrg_ctrl import blrg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      out_last_o,
  input  blrg_sts_t sts_i,
  output blrg_cmd_t cmd_o
);

  blrg_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = (cnt_q == '0);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(DIV_STEPS - 1);
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = sts_i.len_m1;
        state_d     = ST_RAMP;
      end
      ST_RAMP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (cnt_q == '0) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.ramp_step = 1'b1;
            cnt_d           = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/blrg_dp.sv
// blrg_dp: length register, level store, serial divider and ramp accumulator
// depends on blrg_pkg
module blrg_dp import blrg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     block_len_we_i,
  input  logic [LEN_W-1:0]         block_len_i,
  input  logic signed [DATA_W-1:0] target_i,
  input  blrg_cmd_t                cmd_i,
  output blrg_sts_t                sts_o,
  output logic signed [DATA_W-1:0] sample_o
);

  logic [LEN_W-1:0]         block_len_q;
  logic signed [DATA_W-1:0] prev_q;
  logic [LEN_W-1:0]         len_q, len_d;
  logic                     neg_q;
  logic [DATA_W-1:0]        dvd_q;       // dividend in, quotient out
  logic [REM_W-1:0]         rem_q;
  logic signed [ACC_W-1:0]  dq_q;
  logic [REM_W-1:0]         dr_q;
  logic signed [ACC_W-1:0]  q_q;
  logic [REM_W-1:0]         r_q;

  logic signed [DATA_W:0]   diff;
  logic [DATA_W-1:0]        diff_mag;
  logic [LEN_W-1:0]         rem_sh;
  logic                     qbit;
  logic [LEN_W-1:0]         r_sum;
  logic                     r_wrap;
  logic signed [ACC_W-1:0]  q_out;

  // block length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= BLOCK_LEN_RST;
    end else if (block_len_we_i) begin
      block_len_q <= block_len_i;
    end
  end

  // level reached by the previous ramp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.finish) begin
      prev_q <= sample_o;
    end
  end

  always_comb begin
    len_d = block_len_q;
    if (block_len_q < LEN_MIN) begin
      len_d = LEN_MIN;
    end else if (block_len_q > LEN_MAX) begin
      len_d = LEN_MAX;
    end
    diff     = (DATA_W+1)'(target_i) - (DATA_W+1)'(prev_q);
    diff_mag = diff[DATA_W] ? DATA_W'(-diff) : DATA_W'(diff);
    rem_sh   = {rem_q, dvd_q[DATA_W-1]};
    qbit     = (rem_sh >= len_q);
    r_sum    = LEN_W'(r_q) + LEN_W'(dr_q);
    r_wrap   = (r_sum >= len_q);
    // floor quotient to truncation toward zero
    q_out    = ((q_q < 0) && (r_q != '0)) ? q_q + ACC_W'(1) : q_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q <= len_d;
      neg_q <= diff[DATA_W];
      dvd_q <= diff_mag;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DATA_W-2:0], qbit};
      rem_q <= qbit ? REM_W'(rem_sh - len_q) : REM_W'(rem_sh);
    end
    if (cmd_i.setup) begin
      q_q <= ACC_W'(prev_q);
      r_q <= '0;
      if (!neg_q) begin
        dq_q <= ACC_W'(dvd_q);
        dr_q <= rem_q;
      end else if (rem_q == '0) begin
        dq_q <= -ACC_W'(dvd_q);
        dr_q <= '0;
      end else begin
        dq_q <= -ACC_W'(dvd_q) - ACC_W'(1);
        dr_q <= REM_W'(len_q - LEN_W'(rem_q));
      end
    end else if (cmd_i.ramp_step) begin
      if (r_wrap) begin
        q_q <= q_q + dq_q + ACC_W'(1);
        r_q <= REM_W'(r_sum - len_q);
      end else begin
        q_q <= q_q + dq_q;
        r_q <= REM_W'(r_sum);
      end
    end
  end

  assign sts_o.len_m1 = CNT_W'(len_q - LEN_W'(1));
  assign sample_o     = DATA_W'(q_out);

endmodule
